[hdl/qrv_pkg.sv]
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared types and widths for the quaternion vector rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qrv_pkg;

   // field width of every input and rotated component
   localparam int DATA_WIDTH = 16;
   // squared-norm sum of four products
   localparam int N_W        = 2 * DATA_WIDTH + 2;
   // scalar part s = w^2 - u.u and doubled dot product
   localparam int S_W        = 2 * DATA_WIDTH + 3;
   // cross product component
   localparam int C_W        = 2 * DATA_WIDTH + 1;
   // rotated numerator before the divide
   localparam int NUM_W      = S_W + DATA_WIDTH + 2;
   // doubled magnitude plus norm, and doubled norm
   localparam int NUM2_W     = NUM_W + 1;
   localparam int DEN_W      = N_W + 1;
   // quotient bits: rotated magnitude stays below sqrt(3) times the full scale
   localparam int QB         = DATA_WIDTH + 1;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] quat_w;
      logic signed [DATA_WIDTH-1:0] quat_i;
      logic signed [DATA_WIDTH-1:0] quat_j;
      logic signed [DATA_WIDTH-1:0] quat_k;
      logic signed [DATA_WIDTH-1:0] vec_x;
      logic signed [DATA_WIDTH-1:0] vec_y;
      logic signed [DATA_WIDTH-1:0] vec_z;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] rot_x;
      logic signed [DATA_WIDTH-1:0] rot_y;
      logic signed [DATA_WIDTH-1:0] rot_z;
      logic                         degenerate;
      logic                         clipped;
   } rsp_type;

   // data that rides alongside the divider
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] vec_x;
      logic signed [DATA_WIDTH-1:0] vec_y;
      logic signed [DATA_WIDTH-1:0] vec_z;
      logic                         degenerate;
      logic [2:0]                   neg;
   } side_type;

   // pipeline control between the stage modules
   typedef struct packed {
      logic adv;
      logic valid;
   } flow_type;

endpackage

`default_nettype wire

[hdl/qrv_front.sv]
// ----------------------------------------------------------------------------
// qrv_front
// Four-stage arithmetic front end: products, sums, scaled terms, numerators.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_front import qrv_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire flow_type            flow_in,
   input  wire req_type             req_in,
   output logic                     valid_out,
   output logic [NUM2_W-1:0]        num2_out [3],
   output logic [DEN_W-1:0]         den2_out,
   output side_type                 side_out
);

   localparam int P_W = 2 * DATA_WIDTH;
   localparam int T_W = S_W + DATA_WIDTH;
   localparam int W_W = C_W + DATA_WIDTH;

   logic [3:0] vld_ff;

   // stage 1 registers
   req_type               r1_ff;
   logic signed [P_W-1:0] ww_ff, xx_ff, yy_ff, zz_ff, dx_ff, dy_ff, dz_ff;
   logic signed [P_W-1:0] yz_ff, zy_ff, zx_ff, xz_ff, xy_ff, yx_ff;

   // stage 2 registers
   req_type               r2_ff;
   logic signed [N_W-1:0] n_ff;
   logic signed [S_W-1:0] s_ff, d_ff;
   logic signed [C_W-1:0] cx_ff, cy_ff, cz_ff;
   logic                  deg2_ff;

   // stage 3 registers
   req_type               r3_ff;
   logic [N_W-1:0]        n3_ff;
   logic                  deg3_ff;
   logic signed [T_W-1:0] tsx_ff, tsy_ff, tsz_ff, tdx_ff, tdy_ff, tdz_ff;
   logic signed [W_W-1:0] twx_ff, twy_ff, twz_ff;

   // stage 4 registers
   logic [NUM2_W-1:0]     num2_ff [3];
   logic [DEN_W-1:0]      den2_ff;
   side_type              side_ff;

   logic signed [N_W-1:0]   n_in;
   logic signed [N_W-1:0]   uu_in;
   logic signed [N_W-1:0]   dot_in;
   logic signed [NUM_W-1:0] nn_in [3];
   logic [NUM_W-1:0]        mag_in [3];
   logic [2:0]              neg_in;

   // sums of products for stage 2
   always_comb begin
      uu_in  = N_W'(xx_ff) + N_W'(yy_ff) + N_W'(zz_ff);
      n_in   = N_W'(ww_ff) + uu_in;
      dot_in = N_W'(dx_ff) + N_W'(dy_ff) + N_W'(dz_ff);
   end

   // numerators, signs and magnitudes for stage 4
   always_comb begin
      nn_in[0] = NUM_W'(tsx_ff) + NUM_W'(tdx_ff) + (NUM_W'(twx_ff) <<< 1);
      nn_in[1] = NUM_W'(tsy_ff) + NUM_W'(tdy_ff) + (NUM_W'(twy_ff) <<< 1);
      nn_in[2] = NUM_W'(tsz_ff) + NUM_W'(tdz_ff) + (NUM_W'(twz_ff) <<< 1);
      for (int c = 0; c < 3; c++) begin
         neg_in[c] = nn_in[c][NUM_W-1];
         mag_in[c] = neg_in[c] ? $unsigned(-nn_in[c]) : $unsigned(nn_in[c]);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (flow_in.adv) begin
         vld_ff <= {vld_ff[2:0], flow_in.valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (flow_in.adv) begin
         r1_ff <= req_in;
         ww_ff <= req_in.quat_w * req_in.quat_w;
         xx_ff <= req_in.quat_i * req_in.quat_i;
         yy_ff <= req_in.quat_j * req_in.quat_j;
         zz_ff <= req_in.quat_k * req_in.quat_k;
         dx_ff <= req_in.quat_i * req_in.vec_x;
         dy_ff <= req_in.quat_j * req_in.vec_y;
         dz_ff <= req_in.quat_k * req_in.vec_z;
         yz_ff <= req_in.quat_j * req_in.vec_z;
         zy_ff <= req_in.quat_k * req_in.vec_y;
         zx_ff <= req_in.quat_k * req_in.vec_x;
         xz_ff <= req_in.quat_i * req_in.vec_z;
         xy_ff <= req_in.quat_i * req_in.vec_y;
         yx_ff <= req_in.quat_j * req_in.vec_x;

         r2_ff   <= r1_ff;
         n_ff    <= n_in;
         s_ff    <= S_W'(ww_ff) - S_W'(uu_in);
         d_ff    <= S_W'(dot_in) <<< 1;
         cx_ff   <= C_W'(yz_ff) - C_W'(zy_ff);
         cy_ff   <= C_W'(zx_ff) - C_W'(xz_ff);
         cz_ff   <= C_W'(xy_ff) - C_W'(yx_ff);
         deg2_ff <= (n_in == '0);

         r3_ff   <= r2_ff;
         n3_ff   <= $unsigned(n_ff);
         deg3_ff <= deg2_ff;
         tsx_ff  <= s_ff * r2_ff.vec_x;
         tsy_ff  <= s_ff * r2_ff.vec_y;
         tsz_ff  <= s_ff * r2_ff.vec_z;
         tdx_ff  <= d_ff * r2_ff.quat_i;
         tdy_ff  <= d_ff * r2_ff.quat_j;
         tdz_ff  <= d_ff * r2_ff.quat_k;
         twx_ff  <= cx_ff * r2_ff.quat_w;
         twy_ff  <= cy_ff * r2_ff.quat_w;
         twz_ff  <= cz_ff * r2_ff.quat_w;

         for (int c = 0; c < 3; c++) begin
            num2_ff[c] <= {mag_in[c], 1'b0} + NUM2_W'(n3_ff);
         end
         den2_ff            <= {n3_ff, 1'b0};
         side_ff.vec_x      <= r3_ff.vec_x;
         side_ff.vec_y      <= r3_ff.vec_y;
         side_ff.vec_z      <= r3_ff.vec_z;
         side_ff.degenerate <= deg3_ff;
         side_ff.neg        <= neg_in;
      end
   end

   assign valid_out = vld_ff[3];
   assign num2_out  = num2_ff;
   assign den2_out  = den2_ff;
   assign side_out  = side_ff;

endmodule

`default_nettype wire

[hdl/qrv_div.sv]
// ----------------------------------------------------------------------------
// qrv_div
// Pipelined restoring divider, one quotient bit per stage, three lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_div import qrv_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire flow_type            flow_in,
   input  wire logic [NUM2_W-1:0]   num2_in [3],
   input  wire logic [DEN_W-1:0]    den2_in,
   input  wire side_type            side_in,
   output logic                     valid_out,
   output logic [QB-1:0]            quo_out [3],
   output side_type                 side_out
);

   logic [QB-1:0]     vld_ff;
   logic [NUM2_W-1:0] rem_ff  [QB][3];
   logic [QB-1:0]     quo_ff  [QB][3];
   logic [DEN_W-1:0]  den_ff  [QB];
   side_type          side_ff [QB];

   // shift valid bits down the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (flow_in.adv) begin
         vld_ff <= {vld_ff[QB-2:0], flow_in.valid};
      end
   end

   for (genvar k = 0; k < QB; k++) begin : g_stage
      localparam int B = QB - 1 - k;
      logic [NUM2_W-1:0] rem_prev [3];
      logic [QB-1:0]     quo_prev [3];
      logic [DEN_W-1:0]  den_prev;
      side_type          side_prev;
      logic [NUM2_W-1:0] trial;

      if (k == 0) begin : g_first
         always_comb begin
            rem_prev  = num2_in;
            quo_prev  = '{default: '0};
            den_prev  = den2_in;
            side_prev = side_in;
         end
      end else begin : g_next
         always_comb begin
            rem_prev  = rem_ff[k-1];
            quo_prev  = quo_ff[k-1];
            den_prev  = den_ff[k-1];
            side_prev = side_ff[k-1];
         end
      end

      assign trial = NUM2_W'(den_prev) << B;

      // subtract the shifted divisor where it fits, set the quotient bit
      always_ff @(posedge clock) begin
         if (flow_in.adv) begin
            for (int c = 0; c < 3; c++) begin
               if (rem_prev[c] >= trial) begin
                  rem_ff[k][c] <= rem_prev[c] - trial;
                  quo_ff[k][c] <= quo_prev[c] | (QB'(1) << B);
               end else begin
                  rem_ff[k][c] <= rem_prev[c];
                  quo_ff[k][c] <= quo_prev[c];
               end
            end
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign valid_out = vld_ff[QB-1];
   assign quo_out   = quo_ff[QB-1];
   assign side_out  = side_ff[QB-1];

endmodule

`default_nettype wire

[hdl/quaternion_rotate_vector_unit.sv]
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_unit
// Rotates a Q8.8 vector by a Q1.14 quaternion, rounded and saturated.
// ----------------------------------------------------------------------------
//   channel | direction | payload  | handshake
//   req_    | in        | req_type | req_valid / req_stall
//   rsp_    | out       | rsp_type | rsp_valid / rsp_stall
//
// One beat enters per cycle while req_stall is low; the path runs through 4 arithmetic
// stages, 17 divider stages set by the quotient width and 1 output register.
// Reset clears all valid bits and the skid slot; payload is not reset.
// A stalled output beat parks in a one-entry skid, which then stalls req_.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotate_vector_unit import qrv_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   flow_type          flow;
   logic              f_valid;
   logic [NUM2_W-1:0] f_num2 [3];
   logic [DEN_W-1:0]  f_den2;
   side_type          f_side;
   logic              d_valid;
   logic [QB-1:0]     d_quo [3];
   side_type          d_side;

   logic              out_valid_ff;
   rsp_type           out_ff;
   logic              skid_full_ff;
   rsp_type           skid_ff;
   rsp_type           res;
   logic              take;
   logic              push;

   logic signed [DATA_WIDTH-1:0] rot [3];
   logic [2:0]                   sat;

   // hold the whole pipeline while the skid is occupied
   assign flow.adv   = !skid_full_ff;
   assign flow.valid = req_valid;
   assign req_stall  = skid_full_ff;

   qrv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .flow_in   (flow),
      .req_in    (req_data),
      .valid_out (f_valid),
      .num2_out  (f_num2),
      .den2_out  (f_den2),
      .side_out  (f_side)
   );

   qrv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .flow_in   ('{adv: flow.adv, valid: f_valid}),
      .num2_in   (f_num2),
      .den2_in   (f_den2),
      .side_in   (f_side),
      .valid_out (d_valid),
      .quo_out   (d_quo),
      .side_out  (d_side)
   );

   // apply sign and saturate each component
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         if (d_side.neg[c]) begin
            sat[c] = d_quo[c] > QB'(2 ** (DATA_WIDTH - 1));
            rot[c] = sat[c] ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                            : DATA_WIDTH'(-$signed({1'b0, d_quo[c]}));
         end else begin
            sat[c] = d_quo[c] > QB'(2 ** (DATA_WIDTH - 1) - 1);
            rot[c] = sat[c] ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : DATA_WIDTH'(d_quo[c]);
         end
      end
      if (d_side.degenerate) begin
         res.rot_x      = d_side.vec_x;
         res.rot_y      = d_side.vec_y;
         res.rot_z      = d_side.vec_z;
         res.degenerate = 1'b1;
         res.clipped    = 1'b0;
      end else begin
         res.rot_x      = rot[0];
         res.rot_y      = rot[1];
         res.rot_z      = rot[2];
         res.degenerate = 1'b0;
         res.clipped    = |sat;
      end
   end

   assign take = out_valid_ff && !rsp_stall;
   assign push = d_valid && flow.adv;

   // output register with one-entry skid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (take) begin
            skid_full_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_full_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (take) begin
            out_ff <= skid_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || take) begin
            out_ff <= res;
         end else begin
            skid_ff <= res;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // skid only fills behind a waiting output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff |-> out_valid_ff)
      else $error("skid holds a beat while output is empty");

   // a parked beat stays until the output moves
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff && !take) |=> skid_full_ff)
      else $error("skid beat lost without output transfer");

   // identity results never report saturation
   a_deg_no_clip: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_ff.degenerate) |-> !out_ff.clipped)
      else $error("degenerate beat flagged as clipped");

   // when the skid drains, the output remains valid with the parked beat
   a_drain_keeps_valid: assert property (@(posedge clock) disable iff (reset)
      (skid_full_ff && take) |=> (out_valid_ff && !skid_full_ff))
      else $error("skid drain dropped the output beat");

endmodule

`default_nettype wire
